[rtl/csr5_tile_descriptor_offsets_macros.svh]
// ----------------------------------------------------------------------------
// csr5 tile descriptor assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef CSR5_TILE_DESCRIPTOR_OFFSETS_MACROS_SVH
`define CSR5_TILE_DESCRIPTOR_OFFSETS_MACROS_SVH

// assertion that is switched off while reset is high
`define CSR5TD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// assertion that is also checked during reset
`define CSR5TD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/csr5td_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr5td_pkg
// types, constants and helpers shared by the csr5 tile descriptor blocks
// ----------------------------------------------------------------------------
package csr5td_pkg;

  localparam int ADDR_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic       REG_TILE_DEPTH   = 1'b0;
  localparam logic [5:0] TILE_DEPTH_RESET = 6'd4;
  localparam logic [5:0] DEPTH_LIMIT      = 6'd32;
  localparam logic [7:0] OFFSET_MAX       = 8'hFF;

  typedef struct packed {
    logic [1:0] column_index;
    logic [7:0] flag_offset;
    logic       next_empty;
    logic       tile_last;
  } result_t;

  // up to two results leave the core per item, first one first
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[5:0];
  endfunction

endpackage

[rtl/csr5td_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr5td_core
// per-column offset computation and tile state
// ----------------------------------------------------------------------------
module csr5td_core
  import csr5td_pkg::*;
#(
  parameter int COLUMNS_PER_TILE = 4,
  parameter int MAX_TILE_DEPTH   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [31:0] flags,
  input  logic [5:0]  tile_depth,
  output push_t       push
);

  localparam int CW = (COLUMNS_PER_TILE > 2) ? $clog2(COLUMNS_PER_TILE) : 1;
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS_PER_TILE - 1);
  localparam logic [5:0] DEPTH_CAP =
    (MAX_TILE_DEPTH < 32) ? 6'(MAX_TILE_DEPTH) : DEPTH_LIMIT;

  logic [CW-1:0] column_counter, column_counter_next;
  logic          held_valid, held_valid_next;
  logic [7:0]    held_offset, held_offset_next;
  logic [7:0]    running_offset, running_offset_next;

  logic [5:0]    depth_eff;
  logic [31:0]   mask;
  logic [31:0]   masked;
  logic [5:0]    ones;
  logic          first_col;
  logic [CW-1:0] col;
  logic [8:0]    sum;
  result_t       held_res;
  result_t       last_res;

  always_comb begin
    depth_eff = (tile_depth > DEPTH_CAP) ? DEPTH_CAP : tile_depth;
    for (int r = 0; r < 32; r++) begin
      mask[r] = 6'(r) < depth_eff;
    end
    first_col = (column_counter == '0) || !held_valid;
    masked    = flags & mask;
    if (column_counter == '0) begin
      masked[0] = 1'b1;
    end
    ones = popcount32(masked);
    col  = first_col ? '0 : column_counter;
    sum  = {1'b0, running_offset} + 9'(ones);

    held_res.column_index = 2'(column_counter - CW'(1));
    held_res.flag_offset  = held_offset;
    held_res.next_empty   = (masked == '0);
    held_res.tile_last    = 1'b0;

    if (first_col) begin
      held_offset_next    = '0;
      running_offset_next = 8'(ones);
    end else begin
      held_offset_next    = running_offset;
      running_offset_next = sum[8] ? OFFSET_MAX : sum[7:0];
    end

    last_res.column_index = 2'(col);
    last_res.flag_offset  = held_offset_next;
    last_res.next_empty   = 1'b0;
    last_res.tile_last    = 1'b1;

    push.first  = first_col ? last_res : held_res;
    push.second = last_res;
    push.count  = 2'(!first_col) + 2'(col == LAST_COL);

    if (col == LAST_COL) begin
      // tile ends here
      held_valid_next     = 1'b0;
      held_offset_next    = '0;
      running_offset_next = '0;
      column_counter_next = '0;
    end else begin
      held_valid_next     = 1'b1;
      column_counter_next = col + CW'(1);
    end

    if (!advance) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      held_valid     <= 1'b0;
      held_offset    <= '0;
      running_offset <= '0;
    end else if (advance) begin
      column_counter <= column_counter_next;
      held_valid     <= held_valid_next;
      held_offset    <= held_offset_next;
      running_offset <= running_offset_next;
    end
  end

endmodule

[rtl/csr5td_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr5td_queue
// small result queue that takes up to two results per cycle
// ----------------------------------------------------------------------------
module csr5td_queue
  import csr5td_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  input  logic              pop,
  output logic [QCNT_W-1:0] level,
  output result_t           head
);

  result_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;

  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      level  <= level + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

endmodule

[rtl/csr5_tile_descriptor_offsets.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr5_tile_descriptor_offsets
// flag offset and next-empty generation for the columns of csr5 tiles
// ----------------------------------------------------------------------------
// Takes one tile column per cycle while the output queue has room. A column
// is held in the input register and goes through a masked popcount and a
// saturating add combinationally, and its results are written into a
// four-entry output queue from which they leave in order. Each result but a
// tile's last describes the previous column, since next_empty needs the next
// one: the first column of a tile yields nothing and the last yields two.
// Input is taken while the queue holds at most two results, so with the
// result side always ready the block sustains one column per cycle; the
// popcount and add are combinational and do not hold the flow.
module csr5_tile_descriptor_offsets
  import csr5td_pkg::*;
#(
  parameter int COLUMNS_PER_TILE = 4,
  parameter int MAX_TILE_DEPTH   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              column_valid,
  output logic              column_ready,
  input  logic [31:0]       column_flags,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [1:0]        column_index,
  output logic [7:0]        flag_offset,
  output logic              next_empty,
  output logic              tile_last
);

  logic [5:0]        tile_depth;
  logic              in_full;
  logic [31:0]       flags_q;
  logic              advance;
  logic              pop;
  logic [QCNT_W-1:0] level;
  push_t             push;
  result_t           head;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TILE_DEPTH) ? {26'd0, tile_depth} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_depth <= TILE_DEPTH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TILE_DEPTH) begin
      tile_depth <= pwdata[5:0];
    end
  end

  // input register, drains while the queue has room for two results
  assign advance      = in_full && (level <= QCNT_W'(QUEUE_DEPTH - 2));
  assign column_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (column_ready) begin
      in_full <= column_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (column_ready && column_valid) begin
      flags_q <= column_flags;
    end
  end

  csr5td_core #(
    .COLUMNS_PER_TILE (COLUMNS_PER_TILE),
    .MAX_TILE_DEPTH   (MAX_TILE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .flags      (flags_q),
    .tile_depth (tile_depth),
    .push       (push)
  );

  assign result_valid = (level != '0);
  assign pop          = result_valid && result_ready;

  csr5td_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .level (level),
    .head  (head)
  );

  assign column_index = head.column_index;
  assign flag_offset  = head.flag_offset;
  assign next_empty   = head.next_empty;
  assign tile_last    = head.tile_last;

endmodule

[rtl/csr5td_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr5td_checker
// port-level checks on the csr5 tile descriptor, bound to the top level
// ----------------------------------------------------------------------------
`include "csr5_tile_descriptor_offsets_macros.svh"

module csr5td_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] column_index,
  input logic [7:0] flag_offset,
  input logic       next_empty,
  input logic       tile_last
);

  // no result survives a reset
  `CSR5TD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)

  // config port never stalls
  `CSR5TD_ASSERT(a_pready_high, clk, rst, pready)

  // the last column of a tile has no following column
  `CSR5TD_ASSERT(a_last_no_empty, clk, rst, result_valid && tile_last |-> !next_empty)

  // a stalled item holds its payload
  `CSR5TD_ASSERT(a_result_hold, clk, rst,
    result_valid && !result_ready |=> result_valid && $stable(column_index) &&
    $stable(flag_offset) && $stable(next_empty) && $stable(tile_last))

endmodule

bind csr5_tile_descriptor_offsets csr5td_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .column_index (column_index),
  .flag_offset  (flag_offset),
  .next_empty   (next_empty),
  .tile_last    (tile_last)
);
